/* design/slp_pkg.sv */
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants for the searchable stack and its storage cells.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int COUNT_FIELD_W = 7;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } slp_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } slp_status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_HOLD   = 2'd2
    } slp_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } slp_shift_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } slp_tok_t;

endpackage

/* design/slp_cell.sv */
// ----------------------------------------------------------------------------
// slp_cell
// One stack position: holds a word, shifts with its neighbours on push and
// pop, and passes the search probe on to the next position.
// ----------------------------------------------------------------------------
module slp_cell #(
    parameter int DEPTH = slp_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slp_pkg::slp_shift_t         shift,
    input  logic [slp_pkg::WORD_W-1:0]  above_word,
    input  logic [slp_pkg::WORD_W-1:0]  below_word,
    input  logic [slp_pkg::WORD_W-1:0]  key,
    input  logic [CW-1:0]               count,
    input  slp_pkg::slp_tok_t           tok_in,
    output logic [slp_pkg::WORD_W-1:0]  word,
    output slp_pkg::slp_tok_t           tok_out
);

    logic [slp_pkg::WORD_W-1:0] word_reg;
    logic [slp_pkg::WORD_W-1:0] word_next;
    slp_pkg::slp_tok_t          tok_reg;
    slp_pkg::slp_tok_t          tok_next;
    logic                       occupied;

    assign occupied = CW'(INDEX) < count;

    always_comb
    begin
        if (shift.push)
        begin
            word_next = above_word;
        end
        else if (shift.pop)
        begin
            word_next = below_word;
        end
        else
        begin
            word_next = word_reg;
        end
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | (tok_in.valid & occupied & (word_reg == key));
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign word    = word_reg;
    assign tok_out = tok_reg;

endmodule

/* design/searchable_lifo_stack.sv */
// ----------------------------------------------------------------------------
// searchable_lifo_stack
// Bounded last-in first-out stack of 32-bit words with a membership search.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel carries an operation in s_tuser and a
// value in s_tdata. Every item gives exactly one result item on the m_
// channel: status in m_tuser, and the popped or top word, the search flag
// and the word count in m_tdata.
// The words sit in a row of cells, the top of the stack in the first cell.
// Push and pop shift the whole row by one position at once, so the result of
// a push, pop or peek is registered in the cycle after the item is accepted;
// back-to-back push, pop and peek items are taken at one per cycle while the
// receiver keeps up.
// A search sends a probe down the row, one cell per cycle; once the probe
// leaves the last cell, its result is written to the output register, or
// later while an earlier result is still held for a stalled receiver; no
// further item is taken until the search result has been written.
// Reset empties the stack and clears the output valid flag; the stored words
// themselves are not cleared.
// While the receiver stalls, the result is held, and a new item is taken only
// in a cycle in which the result register is empty or being read.
// ----------------------------------------------------------------------------
module searchable_lifo_stack #(
    parameter int DEPTH = slp_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // data[31:0], found[32], count[39:33]
    output logic [1:0]  m_tuser   // status[1:0]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = slp_pkg::WORD_W;
    localparam int FW = slp_pkg::COUNT_FIELD_W;

    slp_pkg::slp_state_t   state_reg;
    slp_pkg::slp_state_t   state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [W-1:0]          key_reg;
    logic [W-1:0]          key_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    slp_pkg::slp_status_t  out_status_reg;
    slp_pkg::slp_status_t  out_status_next;
    logic [W-1:0]          out_data_reg;
    logic [W-1:0]          out_data_next;
    logic                  out_found_reg;
    logic                  out_found_next;
    logic [FW-1:0]         out_count_reg;
    logic [FW-1:0]         out_count_next;

    slp_pkg::slp_op_t      op;
    slp_pkg::slp_shift_t   shift;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  launch;
    logic [W-1:0]          words [DEPTH];
    slp_pkg::slp_tok_t     toks  [DEPTH+1];

    assign op      = slp_pkg::slp_op_t'(s_tuser);
    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign accept  = s_tvalid & s_tready;
    assign toks[0] = '{valid: launch, hit: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [W-1:0] above;
            logic [W-1:0] below;
            if (gi == 0)
            begin : g_top
                assign above = s_tdata;
            end
            else
            begin : g_mid
                assign above = words[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_bottom
                assign below = '0;
            end
            else
            begin : g_inner
                assign below = words[gi+1];
            end
            slp_cell #(
                .DEPTH (DEPTH),
                .INDEX (gi),
                .CW    (CW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .above_word (above),
                .below_word (below),
                .key        (key_next),
                .count      (count_reg),
                .tok_in     (toks[gi]),
                .word       (words[gi]),
                .tok_out    (toks[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        shift           = '0;
        launch          = 1'b0;
        s_tready        = 1'b0;
        unique case (state_reg)
            slp_pkg::S_IDLE:
            begin
                s_tready = ~out_valid_reg | m_tready;
                if (accept)
                begin
                    out_status_next = slp_pkg::ST_DONE;
                    out_data_next   = '0;
                    out_found_next  = 1'b0;
                    unique case (op)
                        slp_pkg::OP_PUSH:
                        begin
                            if (full)
                            begin
                                out_status_next = slp_pkg::ST_FULL;
                            end
                            else
                            begin
                                shift.push = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        slp_pkg::OP_POP:
                        begin
                            if (empty)
                            begin
                                out_status_next = slp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                shift.pop     = 1'b1;
                                count_next    = count_reg - 1'b1;
                                out_data_next = words[0];
                            end
                        end
                        slp_pkg::OP_PEEK:
                        begin
                            if (empty)
                            begin
                                out_status_next = slp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_data_next = words[0];
                            end
                        end
                        slp_pkg::OP_SEARCH:
                        begin
                            key_next   = s_tdata;
                            launch     = 1'b1;
                            state_next = slp_pkg::S_SEARCH;
                        end
                    endcase
                    out_count_next = FW'(count_next);
                    if (op != slp_pkg::OP_SEARCH)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            slp_pkg::S_SEARCH:
            begin
                if (toks[DEPTH].valid)
                begin
                    if (~out_valid_reg | m_tready)
                    begin
                        out_status_next = slp_pkg::ST_DONE;
                        out_data_next   = '0;
                        out_found_next  = toks[DEPTH].hit;
                        out_count_next  = FW'(count_reg);
                        out_valid_next  = 1'b1;
                        state_next      = slp_pkg::S_IDLE;
                    end
                    else
                    begin
                        hit_next   = toks[DEPTH].hit;
                        state_next = slp_pkg::S_HOLD;
                    end
                end
            end
            slp_pkg::S_HOLD:
            begin
                if (~out_valid_reg | m_tready)
                begin
                    out_status_next = slp_pkg::ST_DONE;
                    out_data_next   = '0;
                    out_found_next  = hit_reg;
                    out_count_next  = FW'(count_reg);
                    out_valid_next  = 1'b1;
                    state_next      = slp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slp_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        hit_reg        <= hit_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_found_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

/* sim/searchable_lifo_stack_checker.sv */
// ----------------------------------------------------------------------------
// searchable_lifo_stack_checker
// Predicts and checks every result item of the searchable stack.
// ----------------------------------------------------------------------------
// Watches both stream channels. Each accepted input item is applied to a
// local copy of the stack, and the predicted result is queued. Each accepted
// result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module searchable_lifo_stack_checker #(
    parameter int DEPTH = slp_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,  // data[31:0], found[32], count[39:33]
    input  logic [1:0]  m_tuser,  // status[1:0]
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        slp_pkg::slp_status_t status;
        logic [31:0]          data;
        logic                 found;
        logic [6:0]           count;
    } stack_result_t;

    logic [31:0]   stored_words [DEPTH];
    int            stored_count;
    stack_result_t predicted_results [$];
    stack_result_t oldest;

    task automatic report_failure(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic stack_result_t apply_stack_op(input slp_pkg::slp_op_t op,
                                                     input logic [31:0] val);
        stack_result_t res;
        res.status = slp_pkg::ST_DONE;
        res.data   = '0;
        res.found  = 1'b0;
        case (op)
            slp_pkg::OP_PUSH:
            begin
                if (stored_count >= DEPTH)
                    res.status = slp_pkg::ST_FULL;
                else
                begin
                    stored_words[stored_count] = val;
                    stored_count++;
                end
            end
            slp_pkg::OP_POP:
            begin
                if (stored_count == 0)
                    res.status = slp_pkg::ST_EMPTY;
                else
                begin
                    stored_count--;
                    res.data = stored_words[stored_count];
                end
            end
            slp_pkg::OP_PEEK:
            begin
                if (stored_count == 0)
                    res.status = slp_pkg::ST_EMPTY;
                else
                    res.data = stored_words[stored_count - 1];
            end
            default:
            begin
                for (int i = 0; i < stored_count; i++)
                    if (stored_words[i] == val)
                        res.found = 1'b1;
            end
        endcase
        res.count = 7'(stored_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_count = 0;
            predicted_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                    report_failure($sformatf("unexpected result, tuser %0h tdata %0h",
                                             m_tuser, m_tdata));
                else
                begin
                    oldest = predicted_results.pop_front();
                    if (m_tuser !== oldest.status)
                        report_failure($sformatf("status got %0h, wanted %0h",
                                                 m_tuser, oldest.status));
                    if (m_tdata[31:0] !== oldest.data)
                        report_failure($sformatf("data got %0h, wanted %0h",
                                                 m_tdata[31:0], oldest.data));
                    if (m_tdata[32] !== oldest.found)
                        report_failure($sformatf("found got %0h, wanted %0h",
                                                 m_tdata[32], oldest.found));
                    if (m_tdata[39:33] !== oldest.count)
                        report_failure($sformatf("count got %0d, wanted %0d",
                                                 m_tdata[39:33], oldest.count));
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(
                    apply_stack_op(slp_pkg::slp_op_t'(s_tuser), s_tdata));
            pending = predicted_results.size();
        end
    end

endmodule

/* sim/tb_searchable_lifo_stack.sv */
// ----------------------------------------------------------------------------
// tb_searchable_lifo_stack
// Stimulus and verdict for the searchable last-in first-out stack.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty stack, extreme words and search
// hits and misses. Random runs then fill the stack past full, drain it past
// empty and mix all operations, under three patterns of idling on both
// channels, including one long hold-off of the receiver. The checker module
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_searchable_lifo_stack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 64;
    localparam int ITEM_TARGET  = 1200;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 3000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = slp_pkg::OP_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int sent_items   = 0;
    int phase        = 0;
    int snd_idle_pct = 37;
    int rcv_idle_pct = 51;
    int level        = 0;
    int stuck_cycles = 0;

    logic [31:0] recent_words [16];
    int          recent_wr = 0;

    searchable_lifo_stack #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    searchable_lifo_stack_checker #(
        .DEPTH(STACK_DEPTH)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // The receiver holds off for a long stretch once, as the last phase starts.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 4)
            return $urandom;
        else if (sel <= 6)
            return recent_words[$urandom_range(15)];
        else if (sel == 7)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        else
            return 32'($urandom_range(15));
    endfunction

    task automatic send_op(input slp_pkg::slp_op_t op, input logic [31:0] val);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == slp_pkg::OP_PUSH && level < STACK_DEPTH)
        begin
            level++;
            recent_words[recent_wr] = val;
            recent_wr = (recent_wr + 1) % 16;
        end
        else if (op == slp_pkg::OP_POP && level > 0)
            level--;
        sent_items++;
        if (sent_items == ITEM_TARGET / 3)
        begin
            phase        = 1;
            snd_idle_pct = 51;
            rcv_idle_pct = 37;
        end
        else if (sent_items == 2 * ITEM_TARGET / 3)
        begin
            phase        = 2;
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    initial
    begin
        int mode;
        int extra;
        int roll;
        for (int i = 0; i < 16; i++)
            recent_words[i] = 32'($urandom_range(15));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(slp_pkg::OP_POP, 32'h0000_0000);
        send_op(slp_pkg::OP_PEEK, 32'hFFFF_FFFF);
        send_op(slp_pkg::OP_SEARCH, 32'h0000_0000);
        send_op(slp_pkg::OP_PUSH, 32'h8000_0000);
        send_op(slp_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_op(slp_pkg::OP_PUSH, 32'h0000_0000);
        send_op(slp_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_op(slp_pkg::OP_PEEK, 32'h5555_5555);
        send_op(slp_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_op(slp_pkg::OP_SEARCH, 32'h1234_5678);
        send_op(slp_pkg::OP_SEARCH, 32'h8000_0000);
        send_op(slp_pkg::OP_POP, 32'hAAAA_AAAA);
        send_op(slp_pkg::OP_POP, 32'h0000_0000);
        send_op(slp_pkg::OP_PEEK, 32'h0000_0000);
        send_op(slp_pkg::OP_POP, 32'h0000_0000);
        send_op(slp_pkg::OP_POP, 32'h0000_0000);
        send_op(slp_pkg::OP_POP, 32'h0000_0000);
        send_op(slp_pkg::OP_SEARCH, 32'hFFFF_FFFF);

        mode = 0;
        while (sent_items < ITEM_TARGET)
        begin
            case (mode % 4)
                0:
                begin
                    extra = $urandom_range(4, 1);
                    while (extra > 0)
                    begin
                        roll = $urandom_range(99);
                        if (roll < 80)
                        begin
                            if (level == STACK_DEPTH)
                                extra--;
                            send_op(slp_pkg::OP_PUSH, pick_value());
                        end
                        else if (roll < 88)
                            send_op(slp_pkg::OP_SEARCH, pick_value());
                        else if (roll < 95)
                            send_op(slp_pkg::OP_PEEK, pick_value());
                        else
                            send_op(slp_pkg::OP_POP, pick_value());
                    end
                end
                2:
                begin
                    extra = $urandom_range(3, 1);
                    while (extra > 0)
                    begin
                        roll = $urandom_range(99);
                        if (roll < 75)
                        begin
                            if (level == 0)
                                extra--;
                            send_op(slp_pkg::OP_POP, pick_value());
                        end
                        else if (roll < 85)
                            send_op(slp_pkg::OP_SEARCH, pick_value());
                        else if (roll < 93)
                            send_op(slp_pkg::OP_PEEK, pick_value());
                        else
                            send_op(slp_pkg::OP_PUSH, pick_value());
                    end
                end
                default:
                begin
                    repeat (40)
                    begin
                        roll = $urandom_range(99);
                        if (roll < 35)
                            send_op(slp_pkg::OP_PUSH, pick_value());
                        else if (roll < 65)
                            send_op(slp_pkg::OP_POP, pick_value());
                        else if (roll < 80)
                            send_op(slp_pkg::OP_PEEK, pick_value());
                        else
                            send_op(slp_pkg::OP_SEARCH, pick_value());
                    end
                end
            endcase
            mode++;
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (2 * STACK_DEPTH + 10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/slp_pkg.sv
design/slp_cell.sv
design/searchable_lifo_stack.sv
sim/searchable_lifo_stack_checker.sv
sim/tb_searchable_lifo_stack.sv
